[rtl/sst_pkg.sv]
`default_nettype none

package sst_pkg;

  localparam int OP_W     = 3;
  localparam int ID_W     = 8;
  localparam int POS_W    = 8;
  localparam int CNT_W    = 9;
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int QDEPTH   = 2;

  localparam int IN_FIELDS_W  = OP_W + ID_W + POS_W;
  localparam int OUT_FIELDS_W = 1 + ID_W + CNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ     = 3'd4;

  typedef enum logic [2:0] {
    K_ADD,
    K_REMOVE,
    K_CONTAINS,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  pos;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  member;
    logic             ok;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CHECK
  } back_state_t;

endpackage

`default_nettype wire

[rtl/sst_front.sv]
`default_nettype none

module sst_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sst_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output sst_pkg::cmd_t                      cmd
);
  import sst_pkg::*;

  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int FILL_W = $clog2(QDEPTH + 1);

  function automatic kind_t classify(input logic [OP_W-1:0] op);
    kind_t k;
    unique case (op)
      OP_ADD:      k = K_ADD;
      OP_REMOVE:   k = K_REMOVE;
      OP_CONTAINS: k = K_CONTAINS;
      OP_CLEAR:    k = K_CLEAR;
      OP_READ:     k = K_READ;
      default:     k = K_NOP;
    endcase
    return k;
  endfunction

  cmd_t              queue_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  cmd_t              in_cmd;
  logic              push, pop;

  always_comb begin
    in_cmd.kind = classify(in_tdata[OP_W-1:0]);
    in_cmd.id   = in_tdata[OP_W +: ID_W];
    in_cmd.pos  = in_tdata[OP_W+ID_W +: POS_W];
  end

  assign in_tready = (fill_r != FILL_W'(QDEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = queue_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

[rtl/sst_back.sv]
`default_nettype none

module sst_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cmd_valid,
  output logic                                cmd_ready,
  input  sst_pkg::cmd_t                       cmd,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [sst_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import sst_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [IDX_W-1:0] sparse_mem [CAPACITY];
  logic [ID_W-1:0]  dense_mem  [CAPACITY];

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ID_W-1:0]   last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_data_r, out_data_nxt;
  logic [IDX_W-1:0]  sp_rd_r;
  logic [ID_W-1:0]   dn_rd_r;

  logic [IDX_W-1:0]  sp_raddr, sp_waddr, sp_wdata;
  logic [IDX_W-1:0]  dn_raddr, dn_waddr;
  logic [ID_W-1:0]   dn_wdata;
  logic              sp_we, dn_we;
  logic              out_free, is_member, pos_ok;

  assign out_free  = !out_valid_r || out_tready;
  assign is_member = (CNT_W'(sp_rd_r) < count_r) && (dn_rd_r == cmd_r.id);
  assign pos_ok    = (CNT_W'(cmd_r.pos) < count_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    cmd_ready     = 1'b0;
    sp_raddr      = IDX_W'(cmd_r.id);
    dn_raddr      = IDX_W'(cmd_r.pos);
    sp_we         = 1'b0;
    sp_waddr      = IDX_W'(cmd_r.id);
    sp_wdata      = IDX_W'(count_r);
    dn_we         = 1'b0;
    dn_waddr      = IDX_W'(count_r);
    dn_wdata      = cmd_r.id;
    unique case (state_r)
      ST_IDLE: begin
        cmd_ready = out_free || !(cmd.kind == K_CLEAR || cmd.kind == K_NOP);
        sp_raddr  = IDX_W'(cmd.id);
        dn_raddr  = (cmd.kind == K_READ) ? IDX_W'(cmd.pos) : IDX_W'(count_r - CNT_W'(1));
        if (cmd_valid && cmd_ready) begin
          cmd_nxt = cmd;
          if (cmd.kind == K_CLEAR) begin
            count_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{count: '0, member: '0, ok: 1'b1};
          end else if (cmd.kind == K_NOP) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{count: count_r, member: '0, ok: 1'b0};
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (cmd_r.kind == K_READ) begin
          dn_raddr = IDX_W'(cmd_r.pos);
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{count: count_r, member: pos_ok ? dn_rd_r : '0, ok: pos_ok};
            state_nxt     = ST_IDLE;
          end
        end else begin
          // slot of the id now known, fetch its dense entry
          dn_raddr  = sp_rd_r;
          last_nxt  = dn_rd_r;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        dn_raddr = sp_rd_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          case (cmd_r.kind)
            K_ADD: begin
              if (!is_member && count_r < CAP_CNT) begin
                sp_we     = 1'b1;
                dn_we     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                out_data_nxt = '{count: count_nxt, member: '0, ok: 1'b1};
              end else begin
                out_data_nxt = '{count: count_r, member: '0, ok: 1'b0};
              end
            end
            K_REMOVE: begin
              if (is_member) begin
                // last member fills the vacated slot
                dn_we     = 1'b1;
                dn_waddr  = sp_rd_r;
                dn_wdata  = last_r;
                sp_we     = 1'b1;
                sp_waddr  = IDX_W'(last_r);
                sp_wdata  = sp_rd_r;
                count_nxt = count_r - CNT_W'(1);
                out_data_nxt = '{count: count_nxt, member: '0, ok: 1'b1};
              end else begin
                out_data_nxt = '{count: count_r, member: '0, ok: 1'b0};
              end
            end
            default: begin
              out_data_nxt = '{count: count_r, member: '0, ok: is_member};
            end
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (sp_we) begin
      sparse_mem[sp_waddr] <= sp_wdata;
    end
    if (dn_we) begin
      dense_mem[dn_waddr] <= dn_wdata;
    end
    sp_rd_r <= sparse_mem[sp_raddr];
    dn_rd_r <= dense_mem[dn_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_data_r};

endmodule

`default_nettype wire

[rtl/sparse_set_table.sv]
`default_nettype none

// Sparse set over ids 0 to 255, held as a sparse index memory, a dense member memory and a
// member count. A two-entry command queue takes transfers while the engine behind it works;
// the engine takes add, remove and contains through a sparse read, a dense read, and a check
// and write back, a read at a position through a dense read, and clear or an unknown code
// in its idle state; the steps follow the chain of dependent memory reads. Every transfer in
// yields exactly one result transfer carrying ok, the member for a valid read, and the count
// afterwards. Memory contents are not cleared after reset; membership is always checked
// against the count and the dense entry, so no clearing pass is needed.
module sparse_set_table (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // operation[2:0], id[10:3], position[18:11], zero fill
  input  wire logic [sst_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // ok[0], member[8:1], count[17:9], zero fill
  output logic [sst_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import sst_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  sst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  sst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:9] <= CNT_W'(CAPACITY)))
    else $error("member count above capacity");

  a_member_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[8:1] == '0))
    else $error("member nonzero on failed operation");

  a_full_pending : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> cmd_valid)
    else $error("queue full but no command offered");
`endif

endmodule

`default_nettype wire

[sim/sparse_set_table_tb.sv]
`timescale 1ns / 1ps

module sparse_set_table_tb;
  import sst_pkg::*;

  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_READ + 1'b1;
  localparam logic [OP_W-1:0] OP_LAST = '1;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 12;
  localparam int RANDOM_OPS = 560;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // shadow copy of the set
  logic [IDX_W-1:0] slot_of [CAPACITY];
  logic [ID_W-1:0] dense_ids [CAPACITY];
  logic [CNT_W-1:0] set_size;

  result_t pending_replies[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  sparse_set_table dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t apply_set_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                           logic [POS_W-1:0] pos);
    result_t r;
    logic [IDX_W-1:0] slot;
    logic [ID_W-1:0] last;
    logic present;
    r = '0;
    slot = slot_of[id];
    present = (CNT_W'(slot) < set_size) && (dense_ids[slot] == id);
    case (op)
      OP_ADD: begin
        if (!present && set_size < CAPACITY) begin
          slot_of[id] = set_size[IDX_W-1:0];
          dense_ids[set_size[IDX_W-1:0]] = id;
          set_size = set_size + 1'b1;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (present) begin
          // last member fills the hole
          last = dense_ids[IDX_W'(set_size - 1'b1)];
          dense_ids[slot] = last;
          slot_of[last] = slot;
          set_size = set_size - 1'b1;
          r.ok = 1'b1;
        end
      end
      OP_CONTAINS: r.ok = present;
      OP_CLEAR: begin
        set_size = '0;
        r.ok = 1'b1;
      end
      OP_READ: begin
        if (CNT_W'(pos) < set_size) begin
          r.member = dense_ids[pos];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = set_size;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got_v, want_v);
    mismatches++;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                         input logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 36) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({pos, id, op});
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(apply_set_op(op, id, pos));
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic test_directed();
    int c;
    send_op(OP_CONTAINS, 8'd0, 8'd0);
    send_op(OP_READ, 8'd0, 8'd0);
    send_op(OP_REMOVE, 8'd5, 8'd0);
    send_op(OP_ADD, 8'd0, 8'd0);
    send_op(OP_ADD, 8'hFF, 8'd0);
    send_op(OP_ADD, 8'd0, 8'd0);
    send_op(OP_CONTAINS, 8'd0, 8'd0);
    send_op(OP_CONTAINS, 8'hFF, 8'd0);
    send_op(OP_CONTAINS, 8'h80, 8'd0);
    send_op(OP_READ, 8'd0, 8'd0);
    send_op(OP_READ, 8'd0, 8'd1);
    send_op(OP_READ, 8'd0, 8'd2);
    send_op(OP_READ, 8'd0, 8'hFF);
    for (c = int'(OP_FIRST_UNUSED); c <= int'(OP_LAST); c++)
      send_op(c[OP_W-1:0], 8'hFF, 8'hFF);
    send_op(OP_REMOVE, 8'd0, 8'd0);
    send_op(OP_READ, 8'd0, 8'd0);
    send_op(OP_CONTAINS, 8'd0, 8'd0);
    send_op(OP_REMOVE, 8'hFF, 8'd0);
    send_op(OP_ADD, 8'hAA, 8'd0);
    send_op(OP_ADD, 8'h55, 8'd0);
    send_op(OP_CLEAR, 8'd0, 8'd0);
    // stale entries must not count as members
    send_op(OP_CONTAINS, 8'hAA, 8'd0);
    send_op(OP_READ, 8'd0, 8'd0);
    send_op(OP_ADD, 8'h55, 8'd0);
    send_op(OP_READ, 8'd0, 8'd0);
  endtask

  task automatic test_fill();
    int order [CAPACITY];
    int i, j, t;
    for (i = 0; i < CAPACITY; i++) order[i] = i;
    for (i = CAPACITY - 1; i > 0; i--) begin
      j = int'($urandom_range(i));
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    steady = 1'b1;
    send_op(OP_CLEAR, 8'd0, 8'd0);
    for (i = 0; i < CAPACITY; i++) send_op(OP_ADD, order[i][ID_W-1:0], 8'd0);
    send_op(OP_ADD, order[7][ID_W-1:0], 8'd0);
    send_op(OP_READ, 8'd0, 8'hFF);
    send_op(OP_READ, 8'd0, 8'd0);
    send_op(OP_CONTAINS, 8'd0, 8'd0);
    send_op(OP_CONTAINS, 8'hFF, 8'd0);
    send_op(OP_REMOVE, order[100][ID_W-1:0], 8'd0);
    send_op(OP_REMOVE, order[CAPACITY-1][ID_W-1:0], 8'd0);
    send_op(OP_READ, 8'd0, 8'd100);
    send_op(OP_READ, 8'd0, 8'hFE);
    send_op(OP_ADD, order[100][ID_W-1:0], 8'd0);
    steady = 1'b0;
  endtask

  task automatic test_random();
    int i, roll;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    logic [POS_W-1:0] pos;
    for (i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 2) drain_replies();
      roll = $urandom_range(99);
      if (roll < 32) op = OP_ADD;
      else if (roll < 55) op = OP_REMOVE;
      else if (roll < 73) op = OP_CONTAINS;
      else if (roll < 95) op = OP_READ;
      else if (roll < 97) op = OP_CLEAR;
      else op = OP_W'(OP_LAST - $urandom_range(OP_LAST - OP_FIRST_UNUSED));
      if (set_size != 0 && $urandom_range(1))
        id = dense_ids[IDX_W'($urandom_range(set_size - 1))];
      else id = ID_W'($urandom_range(255));
      if (set_size != 0 && $urandom_range(3) != 0) pos = POS_W'($urandom_range(set_size - 1));
      else pos = POS_W'($urandom_range(255));
      send_op(op, id, pos);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[OUT_FIELDS_W-1:0]);
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected transfer, tdata", int'(out_tdata), 0);
      end else begin
        want = pending_replies.pop_front();
        if (got.ok !== want.ok) report_mismatch("ok", int'(got.ok), int'(want.ok));
        if (got.member !== want.member)
          report_mismatch("member", int'(got.member), int'(want.member));
        if (got.count !== want.count)
          report_mismatch("count", int'(got.count), int'(want.count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < CAPACITY; k++) begin
      slot_of[k] = '0;
      dense_ids[k] = '0;
    end
    set_size = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill();
    test_random();
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/sst_pkg.sv
rtl/sst_front.sv
rtl/sst_back.sv
rtl/sparse_set_table.sv
sim/sparse_set_table_tb.sv
